>>> hw/rtl/label_filter_compact_defines.svh
// ---------------------------------------------------------------------------
// label_filter_compact_defines
// Assertion macros shared by the relabeler RTL.
// ---------------------------------------------------------------------------
`ifndef LABEL_FILTER_COMPACT_DEFINES_SVH
`define LABEL_FILTER_COMPACT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LFC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lfc_pkg.sv
// ---------------------------------------------------------------------------
// lfc_pkg
// Constants and types of the label relabeler.
// ---------------------------------------------------------------------------
package lfc_pkg;

    localparam int OUT_W      = 16;  // result label, count and max width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 13;
    localparam int FIX_W      = 16;  // center / radius fixed point width
    localparam int MASK_W     = 4;
    localparam int FLAG_W     = 2;

    localparam int MIN_BORDER_DIM = 3;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [FLAG_W-1:0]     flags_t;

    // register indexes
    localparam cfg_idx_t REG_REMOVE_MASK = 3'd0;
    localparam cfg_idx_t REG_DIM_X       = 3'd1;
    localparam cfg_idx_t REG_DIM_Y       = 3'd2;
    localparam cfg_idx_t REG_DIM_Z       = 3'd3;
    localparam cfg_idx_t REG_CENTER_X    = 3'd4;
    localparam cfg_idx_t REG_CENTER_Y    = 3'd5;
    localparam cfg_idx_t REG_RADIUS      = 3'd6;

    // remove_mask bits
    localparam int MASK_X_BIT      = 0;
    localparam int MASK_Y_BIT      = 1;
    localparam int MASK_Z_BIT      = 2;
    localparam int MASK_CIRCLE_BIT = 3;

    // label flag bits
    localparam int FLAG_PRESENT_BIT = 0;
    localparam int FLAG_REMOVED_BIT = 1;

    localparam logic FUNC_CENSUS  = 1'b0;
    localparam logic FUNC_REMAP   = 1'b1;
    localparam logic KIND_VOXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

>>> hw/rtl/lfc_if.sv
// ---------------------------------------------------------------------------
// lfc_if
// Valid/ready channels of the relabeler: voxel words in, result words out.
// ---------------------------------------------------------------------------
interface lfc_voxel_if #(
    parameter int LABEL_BITS = 16,
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [LABEL_BITS-1:0] label;
    logic                  last;

    modport source (output valid, func, pos_x, pos_y, pos_z, label, last, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, label, last, output ready);
endinterface

interface lfc_result_if;
    import lfc_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [OUT_W-1:0] new_label;
    logic [OUT_W-1:0] valid_count;
    logic [OUT_W-1:0] max_label;
    logic             pass_end;

    modport source (output valid, kind, new_label, valid_count, max_label, pass_end,
                    input ready);
    modport sink   (input valid, kind, new_label, valid_count, max_label, pass_end,
                    output ready);
endinterface

>>> hw/rtl/lfc_ram.sv
// ---------------------------------------------------------------------------
// lfc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module lfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> hw/rtl/label_filter_compact.sv
// ---------------------------------------------------------------------------
// label_filter_compact
// Two-pass label relabeler: census marks labels present / removed, the
// last census word walks all labels to build a dense map, remap applies it.
// ---------------------------------------------------------------------------
// channel  dir  fields
// voxel    in   func, pos_x, pos_y, pos_z, label, last
// result   out  kind, new_label, valid_count, max_label, pass_end
// cfg_*    in   write enable, register index, data (no read-back)
//
// Census word: flag read, three passes through one shared squarer for dx^2,
// dy^2, r^2, then compare and flag write-back. Remap word: map read, then the
// result load. The last census word adds a walk over the flag RAM (one read
// and one write per cycle), then the summary. After reset a sweep clears the
// flag RAM; no voxel is taken meanwhile, config writes are. A waiting result
// sits in the output register while the next voxel is taken; only a new
// result stalls on it.
// ---------------------------------------------------------------------------
`include "label_filter_compact_defines.svh"

module label_filter_compact #(
    parameter int LABEL_BITS = 16,
    parameter int COORD_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    lfc_voxel_if.sink          voxel,
    lfc_result_if.source       result,
    input  logic               cfg_we,
    input  lfc_pkg::cfg_idx_t  cfg_index,
    input  lfc_pkg::cfg_data_t cfg_data
);
    import lfc_pkg::*;

    localparam int LABEL_COUNT = 1 << LABEL_BITS;
    localparam int IDX_W       = LABEL_BITS + 1;
    localparam int DX_W        = (COORD_BITS + 6 > FIX_W + 2) ? COORD_BITS + 6 : FIX_W + 2;
    localparam int PROD_W      = 2 * DX_W;
    localparam int SQ_W        = PROD_W + 1;
    localparam int CMP_W       = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;

    localparam logic [IDX_W-1:0]      IDX_END   = IDX_W'(LABEL_COUNT);
    localparam logic [LABEL_BITS-1:0] LABEL_TOP = '1;

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_REMAP   = 4'd2;
    localparam logic [3:0] ST_MUL1    = 4'd3;
    localparam logic [3:0] ST_MUL2    = 4'd4;
    localparam logic [3:0] ST_MUL3    = 4'd5;
    localparam logic [3:0] ST_CMP     = 4'd6;
    localparam logic [3:0] ST_WALK    = 4'd7;
    localparam logic [3:0] ST_SUMMARY = 4'd8;

    // config registers
    logic [MASK_W-1:0]       mask_reg;
    logic [DIM_W-1:0]        dim_x_reg, dim_y_reg, dim_z_reg;
    logic signed [FIX_W-1:0] center_x_reg, center_y_reg;
    logic [FIX_W-1:0]        radius_reg;

    // control
    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [OUT_W-1:0]      cnt_reg, cnt_next;
    logic [LABEL_BITS-1:0] hi_reg, hi_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [LABEL_BITS-1:0]   lab_reg;
    logic                    last_reg;
    logic                    border_reg;
    logic signed [DX_W-1:0]  dx_reg, dy_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]         acc_reg, acc_next;
    logic                    out_kind_reg;
    logic [OUT_W-1:0]        out_label_reg, out_count_reg, out_max_reg;
    logic                    out_end_reg;

    // datapath nets
    logic                   in_acc;
    logic                   slot_free;
    logic                   out_load;
    logic                   out_kind;
    logic [OUT_W-1:0]       out_label, out_count, out_max;
    logic                   out_end;
    logic signed [DX_W-1:0] px_fix, py_fix, cx_ext, cy_ext;
    logic signed [DX_W-1:0] mul_op;
    logic                   border_hit;
    logic [LABEL_BITS-1:0]  walk_entry;
    logic                   keep;

    // RAM ports
    logic                  fl_we, fl_re;
    logic [LABEL_BITS-1:0] fl_waddr, fl_raddr;
    flags_t                fl_wdata, fl_rdata;
    logic                  mp_we, mp_re;
    logic [LABEL_BITS-1:0] mp_waddr;
    logic [OUT_W-1:0]      mp_wdata, mp_rdata;

    function automatic logic on_border(input logic [CMP_W-1:0] pos,
                                       input logic [CMP_W-1:0] dim);
        logic big;
        big = dim >= CMP_W'(MIN_BORDER_DIM);
        return big && (pos == '0 || pos == dim - CMP_W'(1));
    endfunction

    lfc_ram #(.WIDTH(FLAG_W), .DEPTH(LABEL_COUNT)) u_flags (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (fl_re),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    lfc_ram #(.WIDTH(OUT_W), .DEPTH(LABEL_COUNT)) u_map (
        .clk   (clk),
        .we    (mp_we),
        .waddr (mp_waddr),
        .wdata (mp_wdata),
        .re    (mp_re),
        .raddr (voxel.label),
        .rdata (mp_rdata)
    );

    assign in_acc    = voxel.valid && voxel.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign voxel.ready = (state_reg == ST_IDLE);

    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.new_label   = out_label_reg;
    assign result.valid_count = out_count_reg;
    assign result.max_label   = out_max_reg;
    assign result.pass_end    = out_end_reg;

    // fixed-point offsets from the circle center, 4 fraction bits
    assign px_fix = {{(DX_W - COORD_BITS - 4){1'b0}}, voxel.pos_x, 4'b0000};
    assign py_fix = {{(DX_W - COORD_BITS - 4){1'b0}}, voxel.pos_y, 4'b0000};
    assign cx_ext = {{(DX_W - FIX_W){center_x_reg[FIX_W-1]}}, center_x_reg};
    assign cy_ext = {{(DX_W - FIX_W){center_y_reg[FIX_W-1]}}, center_y_reg};

    assign border_hit =
        (mask_reg[MASK_X_BIT] && on_border(CMP_W'(voxel.pos_x), CMP_W'(dim_x_reg))) ||
        (mask_reg[MASK_Y_BIT] && on_border(CMP_W'(voxel.pos_y), CMP_W'(dim_y_reg))) ||
        (mask_reg[MASK_Z_BIT] && on_border(CMP_W'(voxel.pos_z), CMP_W'(dim_z_reg)));

    assign walk_entry = LABEL_BITS'(idx_reg - IDX_W'(1));
    assign keep = fl_rdata[FLAG_PRESENT_BIT] && !fl_rdata[FLAG_REMOVED_BIT] &&
                  (walk_entry != '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        acc_next   = acc_reg;
        mul_op     = dx_reg;
        fl_we      = 1'b0;
        fl_waddr   = idx_reg[LABEL_BITS-1:0];
        fl_wdata   = '0;
        fl_re      = 1'b0;
        fl_raddr   = voxel.label;
        mp_we      = 1'b0;
        mp_re      = 1'b0;
        mp_waddr   = walk_entry;
        mp_wdata   = '0;
        out_load   = 1'b0;
        out_kind   = KIND_VOXEL;
        out_label  = '0;
        out_count  = '0;
        out_max    = '0;
        out_end    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                fl_we = 1'b1;
                if (idx_reg[LABEL_BITS-1:0] == LABEL_TOP)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (voxel.func == FUNC_REMAP)
                    begin
                        mp_re      = 1'b1;
                        state_next = ST_REMAP;
                    end
                    else
                    begin
                        fl_re = 1'b1;
                        if (voxel.label > hi_reg)
                        begin
                            hi_next = voxel.label;
                        end
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_REMAP:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_VOXEL;
                    out_label  = (lab_reg == '0) ? '0 : mp_rdata;
                    out_end    = last_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL1:
            begin
                mul_op     = dx_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                mul_op     = dy_reg;
                acc_next   = {1'b0, prod_reg};
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                mul_op     = DX_W'(signed'({1'b0, radius_reg}));
                acc_next   = acc_reg + {1'b0, prod_reg};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // flags word read at accept is still held on the RAM output
                fl_we    = 1'b1;
                fl_waddr = lab_reg;
                fl_wdata = fl_rdata;
                fl_wdata[FLAG_PRESENT_BIT] = 1'b1;
                if (border_reg ||
                    (mask_reg[MASK_CIRCLE_BIT] && (acc_reg > {1'b0, prod_reg})))
                begin
                    fl_wdata[FLAG_REMOVED_BIT] = 1'b1;
                end
                if (last_reg)
                begin
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                // read entry idx, retire entry idx-1
                if (idx_reg != IDX_END)
                begin
                    fl_re    = 1'b1;
                    fl_raddr = idx_reg[LABEL_BITS-1:0];
                end
                if (idx_reg != '0)
                begin
                    fl_we    = 1'b1;
                    fl_waddr = walk_entry;
                    mp_we    = 1'b1;
                    if (keep)
                    begin
                        cnt_next = cnt_reg + OUT_W'(1);
                        mp_wdata = cnt_reg + OUT_W'(1);
                    end
                end
                if (idx_reg == IDX_END)
                begin
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_SUMMARY;
                    out_count  = cnt_reg;
                    out_max    = OUT_W'(hi_reg);
                    out_end    = 1'b1;
                    hi_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            dim_x_reg     <= DIM_W'(1);
            dim_y_reg     <= DIM_W'(1);
            dim_z_reg     <= DIM_W'(1);
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_REMOVE_MASK: mask_reg     <= cfg_data[MASK_W-1:0];
                    REG_DIM_X:       dim_x_reg    <= cfg_data[DIM_W-1:0];
                    REG_DIM_Y:       dim_y_reg    <= cfg_data[DIM_W-1:0];
                    REG_DIM_Z:       dim_z_reg    <= cfg_data[DIM_W-1:0];
                    REG_CENTER_X:    center_x_reg <= signed'(cfg_data[FIX_W-1:0]);
                    REG_CENTER_Y:    center_y_reg <= signed'(cfg_data[FIX_W-1:0]);
                    REG_RADIUS:      radius_reg   <= cfg_data[FIX_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_op * mul_op;
        acc_reg  <= acc_next;
        if (in_acc)
        begin
            lab_reg    <= voxel.label;
            last_reg   <= voxel.last;
            border_reg <= border_hit;
            dx_reg     <= px_fix - cx_ext;
            dy_reg     <= py_fix - cy_ext;
        end
        if (out_load)
        begin
            out_kind_reg  <= out_kind;
            out_label_reg <= out_label;
            out_count_reg <= out_count;
            out_max_reg   <= out_max;
            out_end_reg   <= out_end;
        end
    end

    `LFC_ASSERT_IMPL(a_no_overwrite, out_load, !result.valid || result.ready, "result word overwritten while stalled")
    `LFC_ASSERT_IMPL(a_walk_bound, state_reg == ST_WALK, idx_reg <= IDX_END, "walk index past end of label range")
    `LFC_ASSERT_NEXT(a_hi_cleared, state_reg == ST_SUMMARY && out_load, hi_reg == '0, "highest label not cleared after summary")
    `LFC_ASSERT_IMPL(a_ram_quiet, state_reg == ST_IDLE || state_reg == ST_REMAP, !fl_we && !mp_we, "label RAM written outside census or walk")

endmodule

>>> bench/lfc_checker.sv
// ---------------------------------------------------------------------------
// lfc_checker
// Watches the voxel, result and register ports of the relabeler, keeps its
// own copy of the label flags, the dense label map and the registers, and
// compares every result word field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfc_checker (
    input  logic               clk,
    input  logic               rst_n,
    lfc_voxel_if               vox,
    lfc_result_if              res,
    input  logic               cfg_we,
    input  lfc_pkg::cfg_idx_t  cfg_index,
    input  lfc_pkg::cfg_data_t cfg_data,
    output int                 results_owed,
    output int                 fail_count
);
    import lfc_pkg::*;

    localparam int LABELS = 1 << OUT_W;

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] new_label;
        logic [OUT_W-1:0] valid_count;
        logic [OUT_W-1:0] max_label;
        logic             pass_end;
    } result_word_t;

    flags_t              label_state [LABELS];
    logic [OUT_W-1:0]    dense_map [LABELS];
    logic [OUT_W-1:0]    top_label;

    logic [MASK_W-1:0]   rm_mask;
    logic [DIM_W-1:0]    size_x;
    logic [DIM_W-1:0]    size_y;
    logic [DIM_W-1:0]    size_z;
    logic signed [15:0]  ctr_x;
    logic signed [15:0]  ctr_y;
    logic [15:0]         rad;

    result_word_t        owed_q [$];
    result_word_t        want;
    int                  errors;
    int                  survivors;
    logic                gone;

    initial
    begin
        errors = 0;
    end

    function automatic bit on_face(int pos, int dim);
        return dim >= MIN_BORDER_DIM && (pos == 0 || pos == dim - 1);
    endfunction

    // all in 1/16 voxel units, squares compared exactly
    function automatic bit outside_circle(int px, int py);
        longint dx;
        longint dy;
        longint r2;
        dx = longint'(px) * 16 - longint'(ctr_x);
        dy = longint'(py) * 16 - longint'(ctr_y);
        r2 = longint'(rad) * longint'(rad);
        return dx * dx + dy * dy > r2;
    endfunction

    // number surviving labels densely from 1 and clear every flag
    task automatic build_label_map(output int count);
        int n;
        n = 0;
        dense_map[0]   = '0;
        label_state[0] = '0;
        for (int i = 1; i < LABELS; i++)
        begin
            if (label_state[i][FLAG_PRESENT_BIT] && !label_state[i][FLAG_REMOVED_BIT])
            begin
                n++;
                dense_map[i] = n[OUT_W-1:0];
            end
            else
            begin
                dense_map[i] = '0;
            end
            label_state[i] = '0;
        end
        count = n;
    endtask

    task automatic check_field(string fname, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LABELS; i++)
                label_state[i] = '0;
            top_label = '0;
            rm_mask   = '0;
            size_x    = DIM_W'(1);
            size_y    = DIM_W'(1);
            size_z    = DIM_W'(1);
            ctr_x     = '0;
            ctr_y     = '0;
            rad       = '0;
            owed_q.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REMOVE_MASK: rm_mask = cfg_data[MASK_W-1:0];
                    REG_DIM_X:       size_x  = cfg_data[DIM_W-1:0];
                    REG_DIM_Y:       size_y  = cfg_data[DIM_W-1:0];
                    REG_DIM_Z:       size_z  = cfg_data[DIM_W-1:0];
                    REG_CENTER_X:    ctr_x   = cfg_data;
                    REG_CENTER_Y:    ctr_y   = cfg_data;
                    REG_RADIUS:      rad     = cfg_data;
                    default: ;
                endcase
            end

            // a result word here always belongs to an earlier voxel word
            if (res.valid && res.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got kind %0d label %0d",
                             $time, res.kind, res.new_label);
                    errors++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(res.kind));
                    check_field("new_label", want.new_label, res.new_label);
                    check_field("valid_count", want.valid_count, res.valid_count);
                    check_field("max_label", want.max_label, res.max_label);
                    check_field("pass_end", 16'(want.pass_end), 16'(res.pass_end));
                end
            end

            if (vox.valid && vox.ready)
            begin
                if (vox.func == FUNC_CENSUS)
                begin
                    label_state[vox.label][FLAG_PRESENT_BIT] = 1'b1;
                    if (vox.label > top_label)
                        top_label = vox.label;
                    gone = (rm_mask[MASK_X_BIT] && on_face(int'(vox.pos_x), int'(size_x)))
                        || (rm_mask[MASK_Y_BIT] && on_face(int'(vox.pos_y), int'(size_y)))
                        || (rm_mask[MASK_Z_BIT] && on_face(int'(vox.pos_z), int'(size_z)))
                        || (rm_mask[MASK_CIRCLE_BIT]
                            && outside_circle(int'(vox.pos_x), int'(vox.pos_y)));
                    if (gone)
                        label_state[vox.label][FLAG_REMOVED_BIT] = 1'b1;
                    if (vox.last)
                    begin
                        build_label_map(survivors);
                        owed_q.push_back('{kind: KIND_SUMMARY, new_label: '0,
                                           valid_count: survivors[OUT_W-1:0],
                                           max_label: top_label, pass_end: 1'b1});
                        top_label = '0;
                    end
                end
                else
                begin
                    owed_q.push_back('{kind: KIND_VOXEL,
                                       new_label: (vox.label == 0) ? '0 : dense_map[vox.label],
                                       valid_count: '0, max_label: '0, pass_end: vox.last});
                end
            end

            results_owed <= owed_q.size();
        end
        fail_count <= errors;
    end

endmodule

>>> bench/label_filter_compact_tb.sv
// ---------------------------------------------------------------------------
// label_filter_compact_tb
// Drives census and remap passes into the relabeler under several register
// settings with random idling on both channels; the checker predicts and
// compares every result word, this module makes stimulus and the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module label_filter_compact_tb;
    import lfc_pkg::*;

    localparam int COORD_W = 12;
    localparam int LABEL_W = 16;
    localparam int SETTLE  = 16;
    localparam int MASK_ALL = (1 << MASK_X_BIT) | (1 << MASK_Y_BIT)
                            | (1 << MASK_Z_BIT) | (1 << MASK_CIRCLE_BIT);
    // flag clear sweep, ten label walks, slow handshakes, then margin
    localparam int unsigned CYCLE_LIMIT = 4 * (65536 + 10 * 65600 + 1000 * 60);

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    cfg_data_t   cfg_data;

    int          results_owed;
    int          fail_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    int unsigned cycles = 0;
    int          span_x;
    int          span_y;
    int          span_z;
    logic [LABEL_W-1:0] label_pool [8];

    lfc_voxel_if  vox_ch ();
    lfc_result_if res_ch ();

    label_filter_compact u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .voxel     (vox_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .vox          (vox_ch),
        .res          (res_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .results_owed (results_owed),
        .fail_count   (fail_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        res_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("label_filter_compact_tb failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(posedge clk);
    endtask

    task automatic configure(int mask, int dx, int dy, int dz, int cx, int cy, int rad);
        write_reg(REG_REMOVE_MASK, mask);
        write_reg(REG_DIM_X, dx);
        write_reg(REG_DIM_Y, dy);
        write_reg(REG_DIM_Z, dz);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, rad);
        cfg_we <= 1'b0;
        span_x = dx;
        span_y = dy;
        span_z = dz;
    endtask

    // valid stays high across back-to-back words; it only drops for a gap
    task automatic send_word(logic func, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                             logic [COORD_W-1:0] pz, logic [LABEL_W-1:0] lab, logic fin);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            vox_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vox_ch.valid <= 1'b1;
        vox_ch.func  <= func;
        vox_ch.pos_x <= px;
        vox_ch.pos_y <= py;
        vox_ch.pos_z <= pz;
        vox_ch.label <= lab;
        vox_ch.last  <= fin;
        do @(posedge clk); while (!vox_ch.ready);
    endtask

    task automatic drain(int settle);
        vox_ch.valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (settle) @(posedge clk);
    endtask

    // borders are favored so the face tests fire often
    function automatic logic [COORD_W-1:0] pick_coord(int dim);
        int top_pos;
        int roll;
        top_pos = (dim < 1) ? 0 : dim - 1;
        roll    = $urandom_range(0, 9);
        if (roll == 0)
            return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        if (roll < 3)
            return '0;
        if (roll < 5)
            return COORD_W'(top_pos);
        return COORD_W'($urandom_range(0, top_pos));
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label(int zero_pct, int pool_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct)
            return '0;
        if (roll < zero_pct + pool_pct)
            return label_pool[$urandom_range(0, 7)];
        return LABEL_W'($urandom_range(0, (1 << LABEL_W) - 1));
    endfunction

    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return $urandom_range(1, 2);
        if (roll < 6)
            return $urandom_range(3, 4096);
        return $urandom_range(3, 12);
    endfunction

    // one census pass (with stray remap words) and a few remap passes
    task automatic run_round(int census_len, int remap_passes);
        int n;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 9))
                0:       label_pool[i] = LABEL_W'(1);
                1:       label_pool[i] = '1;
                default: label_pool[i] = LABEL_W'($urandom_range(1, (1 << LABEL_W) - 1));
            endcase
        end
        for (int i = 0; i < census_len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(FUNC_REMAP, COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), pick_label(10, 60),
                          1'($urandom_range(0, 1)));
            send_word(FUNC_CENSUS, pick_coord(span_x), pick_coord(span_y), pick_coord(span_z),
                      pick_label(5, 80), i == census_len - 1);
            if ($urandom_range(0, 39) == 0)
                drain(0);
        end
        for (int p = 0; p < remap_passes; p++)
        begin
            n = $urandom_range(20, 45);
            for (int j = 0; j < n; j++)
            begin
                send_word(FUNC_REMAP, COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), pick_label(15, 60), j == n - 1);
                if ($urandom_range(0, 39) == 0)
                    drain(0);
            end
        end
    endtask

    initial
    begin
        int rdx;
        int rdy;
        int rdz;
        int rcx;
        int rcy;
        int rrad;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_REMOVE_MASK;
        cfg_data     <= '0;
        vox_ch.valid <= 1'b0;
        vox_ch.func  <= FUNC_CENSUS;
        vox_ch.pos_x <= '0;
        vox_ch.pos_y <= '0;
        vox_ch.pos_z <= '0;
        vox_ch.label <= '0;
        vox_ch.last  <= 1'b0;
        src_idle_pct = 33;
        snk_idle_pct = 85;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // 7^3 volume, circle of 2.5 voxels around (3,3), every test enabled
        configure(MASK_ALL, 7, 7, 7, 48, 48, 40);
        send_word(FUNC_CENSUS, 3, 3, 3, 7, 1'b0);
        send_word(FUNC_CENSUS, 0, 3, 3, 3, 1'b0);          // x face
        send_word(FUNC_CENSUS, 3, 0, 3, 11, 1'b0);         // y face
        send_word(FUNC_CENSUS, 3, 3, 6, 9, 1'b0);          // z face only
        send_word(FUNC_CENSUS, 1, 1, 3, 100, 1'b0);        // outside circle only
        send_word(FUNC_CENSUS, 3, 3, 3, 0, 1'b0);          // background
        send_word(FUNC_CENSUS, 2, 3, 2, 16'hFFFF, 1'b0);
        send_word(FUNC_CENSUS, 12'hFFF, 12'hFFF, 12'hFFF, 200, 1'b0);  // beyond the volume
        send_word(FUNC_CENSUS, 3, 3, 3, 3, 1'b0);          // removal is sticky
        send_word(FUNC_CENSUS, 3, 4, 3, 1, 1'b0);
        send_word(FUNC_CENSUS, 3, 3, 3, 40000, 1'b1);
        send_word(FUNC_REMAP, 0, 0, 0, 0, 1'b0);
        send_word(FUNC_REMAP, 12'hFFF, 12'hFFF, 12'hFFF, 1, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 3, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 7, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 9, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 100, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 200, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 40000, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 16'hFFFF, 1'b0);
        send_word(FUNC_REMAP, 1, 2, 3, 12345, 1'b1);       // never seen in census
        drain(SETTLE);

        for (int r = 1; r <= 9; r++)
        begin
            if (r == 4)
            begin
                src_idle_pct = 85;
                snk_idle_pct = 33;
            end
            if (r == 7)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case (r)
                1: configure(MASK_ALL, 4096, 4096, 4096, 32767, 32767, 65535);
                2: configure(MASK_ALL, 0, 1, 2, -32768, -32768, 0);
                3: configure(0, 3, 3, 3, 0, 0, 0);
                default:
                begin
                    rdx = pick_dim();
                    rdy = pick_dim();
                    rdz = pick_dim();
                    if ($urandom_range(0, 9) == 0)
                    begin
                        rcx = int'($urandom_range(0, 65535)) - 32768;
                        rcy = int'($urandom_range(0, 65535)) - 32768;
                    end
                    else
                    begin
                        rcx = $urandom_range(0, (rdx * 16 > 32767) ? 32767 : rdx * 16);
                        rcy = $urandom_range(0, (rdy * 16 > 32767) ? 32767 : rdy * 16);
                    end
                    rrad = $urandom_range(rdx * 4, (rdx + rdy) * 8);
                    if (rrad > 65535)
                        rrad = 65535;
                    configure($urandom_range(0, 15), rdx, rdy, rdz, rcx, rcy, rrad);
                end
            endcase
            // a census pass of a single, final word in round 3
            run_round((r == 3) ? 1 : $urandom_range(20, 50), 2);
            drain(SETTLE);
        end

        if (fail_count == 0 && results_owed == 0)
            $display("label_filter_compact_tb passed");
        else
            $display("label_filter_compact_tb failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lfc_pkg.sv
hw/rtl/lfc_if.sv
hw/rtl/lfc_ram.sv
hw/rtl/label_filter_compact.sv
bench/lfc_checker.sv
bench/label_filter_compact_tb.sv
